[rtl/core/smpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared constants, codes and types of the stable min priority queue core.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_PRIO_WIDTH = 16;

    localparam int STATUS_WIDTH = 2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic enq;
        logic deq;
    } smpq_cmd_t;

endpackage

[rtl/core/smpq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: holds an entry, decides whether it stays,
// takes the new item, or shifts from a neighbour.
// ----------------------------------------------------------------------------
module smpq_cell
    import smpq_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int PRIO_WIDTH = DEF_PRIO_WIDTH,
    localparam int CNT_WIDTH = $clog2(CAPACITY + 1)
)
(
    input  logic                  clk,
    input  smpq_cmd_t             cmd,
    input  logic [CNT_WIDTH-1:0]  count,
    input  logic [DATA_WIDTH-1:0] new_data,
    input  logic [PRIO_WIDTH-1:0] new_prio,
    input  logic                  prev_keep,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic [PRIO_WIDTH-1:0] prev_prio,
    input  logic [DATA_WIDTH-1:0] next_data,
    input  logic [PRIO_WIDTH-1:0] next_prio,
    output logic                  keep,
    output logic [DATA_WIDTH-1:0] data,
    output logic [PRIO_WIDTH-1:0] prio
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [PRIO_WIDTH-1:0] prio_reg;
    logic [PRIO_WIDTH-1:0] prio_next;
    logic                  occupied;

    assign occupied = CNT_WIDTH'(INDEX) < count;
    assign keep     = occupied && (prio_reg <= new_prio);

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (cmd.enq && !keep)
        begin
            if (prev_keep)
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
            else
            begin
                data_next = prev_data;
                prio_next = prev_prio;
            end
        end
        else if (cmd.deq)
        begin
            data_next = next_data;
            prio_next = next_prio;
        end
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

[rtl/core/stable_min_priority_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue_core
// Bounded priority queue kept sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
// Each request is an enqueue or a dequeue and produces one result in the
// cycle after it is taken. All cells update in parallel when it is taken
// (they hold, take the new item or shift from a neighbour), so a new request
// is accepted every cycle while the result register is free or being read.
// The lowest priority number is at the head; equal priorities leave in
// arrival order. An enqueue into a full queue and a dequeue from an empty
// one are reported in status and leave the queue unchanged.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_core
    import smpq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int PRIO_WIDTH = DEF_PRIO_WIDTH,
    localparam int CNT_WIDTH = $clog2(CAPACITY + 1),
    localparam int IN_BITS   = DATA_WIDTH + PRIO_WIDTH,
    localparam int IN_TW     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = STATUS_WIDTH + 2 * DATA_WIDTH + 2 * PRIO_WIDTH
                               + CNT_WIDTH + 1,
    localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,  // item_data, item_priority
    input  logic              s_tuser,  // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata   // status, removed_data, removed_priority,
                                        // head_data, head_priority, occupancy,
                                        // empty_flag
);

    logic [CNT_WIDTH-1:0]    count_reg;
    logic [CNT_WIDTH-1:0]    count_next;
    logic                    out_valid_reg;
    logic [STATUS_WIDTH-1:0] status_reg;
    logic [DATA_WIDTH-1:0]   rem_data_reg;
    logic [PRIO_WIDTH-1:0]   rem_prio_reg;
    logic [STATUS_WIDTH-1:0] status_next;

    logic                    accept;
    logic                    full;
    logic                    empty;
    smpq_cmd_t               cmd;
    logic [DATA_WIDTH-1:0]   new_data;
    logic [PRIO_WIDTH-1:0]   new_prio;

    logic [CAPACITY-1:0]     cell_keep;
    logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
    logic [PRIO_WIDTH-1:0]   cell_prio [CAPACITY];

    logic [DATA_WIDTH-1:0]   head_data;
    logic [PRIO_WIDTH-1:0]   head_prio;
    logic [OUT_BITS-1:0]     result;

    assign new_data = s_tdata[DATA_WIDTH-1:0];
    assign new_prio = s_tdata[IN_BITS-1:DATA_WIDTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = count_reg == CNT_WIDTH'(CAPACITY);
    assign empty    = count_reg == '0;

    assign cmd.enq = accept && (s_tuser == OP_ENQ) && !full;
    assign cmd.deq = accept && (s_tuser == OP_DEQ) && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        status_next = STATUS_OK;
        if (s_tuser == OP_ENQ && full)
        begin
            status_next = STATUS_FULL;
        end
        else if (s_tuser == OP_DEQ && empty)
        begin
            status_next = STATUS_EMPTY;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                  prev_keep;
            logic [DATA_WIDTH-1:0] prev_data;
            logic [PRIO_WIDTH-1:0] prev_prio;
            logic [DATA_WIDTH-1:0] next_data;
            logic [PRIO_WIDTH-1:0] next_prio;

            if (i == 0)
            begin : g_first
                assign prev_keep = 1'b1;
                assign prev_data = '0;
                assign prev_prio = '0;
            end
            else
            begin : g_mid
                assign prev_keep = cell_keep[i-1];
                assign prev_data = cell_data[i-1];
                assign prev_prio = cell_prio[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_data = '0;
                assign next_prio = '0;
            end
            else
            begin : g_inner
                assign next_data = cell_data[i+1];
                assign next_prio = cell_prio[i+1];
            end

            smpq_cell #(
                .INDEX      (i),
                .CAPACITY   (CAPACITY),
                .DATA_WIDTH (DATA_WIDTH),
                .PRIO_WIDTH (PRIO_WIDTH)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .new_data  (new_data),
                .new_prio  (new_prio),
                .prev_keep (prev_keep),
                .prev_data (prev_data),
                .prev_prio (prev_prio),
                .next_data (next_data),
                .next_prio (next_prio),
                .keep      (cell_keep[i]),
                .data      (cell_data[i]),
                .prio      (cell_prio[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result fields of the last request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            rem_data_reg <= cmd.deq ? cell_data[0] : '0;
            rem_prio_reg <= cmd.deq ? cell_prio[0] : '0;
        end
    end

    // head and count only move on an accepted request, so they hold while stalled
    assign head_data = empty ? '0 : cell_data[0];
    assign head_prio = empty ? '0 : cell_prio[0];

    assign result = {empty, count_reg, head_prio, head_data,
                     rem_prio_reg, rem_data_reg, status_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(result);

endmodule
